### hw/rtl/pdwp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pdwp_pkg
// Shared types and constants of the peak decimating waveform plotter.
// ============================================================================
package pdwp_pkg;

    localparam int MaxChannels = 8;
    localparam int QueueDepth  = 2;

    localparam int SampleW   = 16;
    localparam int ChannelW  = 3;
    localparam int ColumnW   = 16;
    localparam int RowW      = 12;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 16;

    localparam logic [3:0]  ChannelCountReset    = 4'd2;
    localparam logic [15:0] SamplesPerPointReset = 16'd64;
    localparam logic [11:0] PlotHeightReset      = 12'd450;
    localparam logic [11:0] FirstColumnReset     = 12'd10;

    typedef enum logic [CfgIdxW-1:0] {
        CfgChannelCount    = 2'd0,
        CfgSamplesPerPoint = 2'd1,
        CfgPlotHeight      = 2'd2,
        CfgFirstColumn     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [3:0]  channel_count;
        logic [15:0] samples_per_point;
        logic [11:0] plot_height;
        logic [11:0] first_column;
    } cfg_t;

    // One-cycle pulses after a write that reloads every channel's last point
    typedef struct packed {
        logic rows;
        logic cols;
    } reload_t;

endpackage

### hw/rtl/pdwp_if.sv
`timescale 1ns / 1ps
// ============================================================================
// pdwp_if
// Stream interfaces: incoming audio samples and outgoing line segments.
// ============================================================================
interface pdwp_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pdwp_pkg::SampleW-1:0]    sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface pdwp_point_if;
    logic                                   valid;
    logic                                   ready;
    logic [pdwp_pkg::ChannelW-1:0]          channel;
    logic signed [pdwp_pkg::SampleW-1:0]    peak_sample;
    logic [pdwp_pkg::ColumnW-1:0]           x_from;
    logic [pdwp_pkg::RowW-1:0]              y_from;
    logic [pdwp_pkg::ColumnW-1:0]           x_to;
    logic [pdwp_pkg::RowW-1:0]              y_to;

    modport source (output valid, output channel, output peak_sample, output x_from,
                    output y_from, output x_to, output y_to, input ready);
    modport sink   (input valid, input channel, input peak_sample, input x_from,
                    input y_from, input x_to, input y_to, output ready);
endinterface

### hw/rtl/peak_decimating_waveform_plotter.sv
`timescale 1ns / 1ps
// ============================================================================
// peak_decimating_waveform_plotter
// Peak-magnitude decimator that turns interleaved audio into line segments.
// ============================================================================
//  channel   direction  beat                             handshake
//  samples   in         one signed 16-bit sample         valid / ready
//  points    out        channel, peak, from/to point     valid / ready
//  cfg       in         register index and data          cfg_wr_en, no wait
//
//  One sample is taken per cycle while the queue has room; the per-channel
//  window update in the back part reads and writes its state in the same cycle, which sets that rate.
//  A completed point passes from the queue through the s2, s3 and output registers to points.
//  Reset loads the register defaults and every channel's last point at once.
//  The two-entry queue and the pipeline registers let either side stall alone.
// ============================================================================
module peak_decimating_waveform_plotter #(
    parameter int MAX_CHANNELS = pdwp_pkg::MaxChannels
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pdwp_pkg::CfgIdxW-1:0]    cfg_addr,
    input  logic [pdwp_pkg::CfgDataW-1:0]   cfg_wdata,
    pdwp_sample_if.sink                     samples,
    pdwp_point_if.source                    points
);

    localparam int ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int QW  = ChW + pdwp_pkg::SampleW;

    pdwp_pkg::cfg_t    cfg_reg;
    pdwp_pkg::reload_t reload_reg;

    logic          push_valid;
    logic [QW-1:0] push_data;
    logic          push_ready;
    logic          head_valid;
    logic [QW-1:0] head_data;
    logic          pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count     <= pdwp_pkg::ChannelCountReset;
            cfg_reg.samples_per_point <= pdwp_pkg::SamplesPerPointReset;
            cfg_reg.plot_height       <= pdwp_pkg::PlotHeightReset;
            cfg_reg.first_column      <= pdwp_pkg::FirstColumnReset;
            reload_reg                <= '0;
        end
        else
        begin
            // Reload last points in the cycle after the write, from the updated register
            reload_reg.rows <= cfg_wr_en && (cfg_addr == pdwp_pkg::CfgPlotHeight);
            reload_reg.cols <= cfg_wr_en && (cfg_addr == pdwp_pkg::CfgFirstColumn);
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    pdwp_pkg::CfgChannelCount:    cfg_reg.channel_count     <= cfg_wdata[3:0];
                    pdwp_pkg::CfgSamplesPerPoint: cfg_reg.samples_per_point <= cfg_wdata;
                    pdwp_pkg::CfgPlotHeight:      cfg_reg.plot_height       <= cfg_wdata[11:0];
                    pdwp_pkg::CfgFirstColumn:     cfg_reg.first_column      <= cfg_wdata[11:0];
                    default:                      cfg_reg                   <= cfg_reg;
                endcase
            end
        end
    end

    pdwp_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .samples    (samples),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    pdwp_queue #(
        .WIDTH (QW),
        .DEPTH (pdwp_pkg::QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    pdwp_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .reload     (reload_reg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .points     (points)
    );

endmodule

### hw/rtl/pdwp_front.sv
`timescale 1ns / 1ps
// ============================================================================
// pdwp_front
// Accepts sample beats and tags each with its channel by a rotating counter.
// ============================================================================
module pdwp_front #(
    parameter int MAX_CHANNELS = pdwp_pkg::MaxChannels,
    localparam int ChW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int CntW = $clog2(MAX_CHANNELS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pdwp_pkg::cfg_t                      cfg,
    pdwp_sample_if.sink                         samples,
    output logic                                push_valid,
    output logic [ChW+pdwp_pkg::SampleW-1:0]    push_data,
    input  logic                                push_ready
);

    logic [ChW-1:0]  cur_ch_reg;
    logic [ChW-1:0]  cur_ch_next;
    logic [ChW-1:0]  ch;
    logic [CntW-1:0] active;

    always_comb
    begin
        if (cfg.channel_count == 4'd0)
        begin
            active = CntW'(1);
        end
        else if (32'(cfg.channel_count) > 32'(MAX_CHANNELS))
        begin
            active = CntW'(MAX_CHANNELS);
        end
        else
        begin
            active = CntW'(cfg.channel_count);
        end

        // Fall back to channel 0 when the count was lowered under the counter
        ch = (32'(cur_ch_reg) >= 32'(active)) ? '0 : cur_ch_reg;
        cur_ch_next = (32'(ch) + 32'd1 >= 32'(active)) ? '0 : ch + ChW'(1);
    end

    assign samples.ready = push_ready;
    assign push_valid    = samples.valid;
    assign push_data     = {ch, samples.sample};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_ch_reg <= '0;
        end
        else if (samples.valid && push_ready)
        begin
            cur_ch_reg <= cur_ch_next;
        end
    end

endmodule

### hw/rtl/pdwp_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// pdwp_queue
// Short first-in first-out queue between the front and the back part.
// ============================================================================
module pdwp_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = pdwp_pkg::QueueDepth
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data,
    input  logic             pop
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [CntW-1:0]  count_reg;
    logic             push;
    logic             do_pop;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + CntW'(1);
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/pdwp_back.sv
`timescale 1ns / 1ps
// ============================================================================
// pdwp_back
// Window peak tracking per channel, row scaling and line segment output.
// ============================================================================
module pdwp_back #(
    parameter int MAX_CHANNELS = pdwp_pkg::MaxChannels,
    localparam int ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pdwp_pkg::cfg_t                      cfg,
    input  pdwp_pkg::reload_t                   reload,
    input  logic                                head_valid,
    input  logic [ChW+pdwp_pkg::SampleW-1:0]    head_data,
    output logic                                pop,
    pdwp_point_if.source                        points
);

    // Per-channel window state
    logic [15:0]        win_cnt_reg  [MAX_CHANNELS];
    logic signed [15:0] win_peak_reg [MAX_CHANNELS];
    logic [15:0]        last_col_reg [MAX_CHANNELS];
    logic [11:0]        last_row_reg [MAX_CHANNELS];

    // Update step on the queue head
    logic [ChW-1:0]     head_ch;
    logic signed [15:0] head_sample;
    logic [15:0]        cur_cnt;
    logic signed [15:0] cur_peak;
    logic [16:0]        mag_new;
    logic [16:0]        mag_old;
    logic signed [15:0] upd_peak;
    logic [15:0]        upd_cnt;
    logic [15:0]        spp_eff;
    logic               done;

    // Pipeline registers
    logic               s2_valid_reg;
    logic [ChW-1:0]     s2_ch_reg;
    logic signed [15:0] s2_peak_reg;
    logic               s3_valid_reg;
    logic [ChW-1:0]     s3_ch_reg;
    logic signed [15:0] s3_peak_reg;
    logic signed [28:0] s3_prod_reg;
    logic               out_valid_reg;
    logic [2:0]         out_ch_reg;
    logic signed [15:0] out_peak_reg;
    logic [15:0]        out_x_from_reg;
    logic [11:0]        out_y_from_reg;
    logic [15:0]        out_x_to_reg;
    logic [11:0]        out_y_to_reg;

    logic               out_adv;
    logic               s3_ready;
    logic               s2_ready;

    // Scaling
    logic signed [12:0] height_s;
    logic signed [28:0] prod;
    logic               neg;
    logic [28:0]        abs_p;
    logic [11:0]        q0;
    logic [16:0]        r0;
    logic [11:0]        q;
    logic [11:0]        half;
    logic [11:0]        y_next;
    logic [15:0]        x_from;
    logic [15:0]        x_next;

    assign out_adv  = !out_valid_reg || points.ready;
    assign s3_ready = !s3_valid_reg || out_adv;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign pop      = head_valid && s2_ready;

    always_comb
    begin
        head_ch     = head_data[ChW+15:16];
        head_sample = head_data[15:0];
        cur_cnt     = win_cnt_reg[head_ch];
        cur_peak    = win_peak_reg[head_ch];
        // Magnitude of -32768 comes out as 32768
        mag_new = head_sample[15] ? 17'(-{head_sample[15], head_sample})
                                  : {1'b0, head_sample};
        mag_old = cur_peak[15] ? 17'(-{cur_peak[15], cur_peak})
                               : {1'b0, cur_peak};
        upd_peak = (cur_cnt == 16'd0 || mag_new > mag_old) ? head_sample : cur_peak;
        upd_cnt  = (cur_cnt != 16'hFFFF) ? cur_cnt + 16'd1 : cur_cnt;
        spp_eff  = (cfg.samples_per_point == 16'd0) ? 16'd1 : cfg.samples_per_point;
        done     = (upd_cnt >= spp_eff);
    end

    always_comb
    begin
        height_s = {1'b0, cfg.plot_height};
        prod     = 29'(s2_peak_reg) * 29'(height_s);

        // Divide |product| by 65535: a = 65536*q0 + lo, so a = 65535*q0 + (lo + q0)
        neg   = s3_prod_reg[28];
        abs_p = neg ? -s3_prod_reg : s3_prod_reg;
        q0    = abs_p[27:16];
        r0    = {1'b0, abs_p[15:0]} + {5'b0, q0};
        q     = (r0 >= 17'd65535) ? q0 + 12'd1 : q0;
        half  = {1'b0, cfg.plot_height[11:1]};
        y_next = neg ? half + q : half - q;

        x_from = last_col_reg[s3_ch_reg];
        x_next = (x_from == 16'hFFFF) ? 16'hFFFF : x_from + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                win_cnt_reg[c]  <= '0;
                win_peak_reg[c] <= '0;
                last_col_reg[c] <= {4'b0, pdwp_pkg::FirstColumnReset};
                last_row_reg[c] <= {1'b0, pdwp_pkg::PlotHeightReset[11:1]};
            end
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                // Restart the window once the point is complete
                win_cnt_reg[head_ch]  <= done ? 16'd0 : upd_cnt;
                win_peak_reg[head_ch] <= done ? 16'sd0 : upd_peak;
            end

            if (s2_ready)
            begin
                s2_valid_reg <= pop && done;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s3_valid_reg;
            end

            if (reload.rows || reload.cols)
            begin
                for (int c = 0; c < MAX_CHANNELS; c++)
                begin
                    if (reload.rows)
                    begin
                        last_row_reg[c] <= {1'b0, cfg.plot_height[11:1]};
                    end
                    if (reload.cols)
                    begin
                        last_col_reg[c] <= {4'b0, cfg.first_column};
                    end
                end
            end
            else if (out_adv && s3_valid_reg)
            begin
                last_col_reg[s3_ch_reg] <= x_next;
                last_row_reg[s3_ch_reg] <= y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_ch_reg   <= head_ch;
            s2_peak_reg <= upd_peak;
        end
        if (s3_ready)
        begin
            s3_ch_reg   <= s2_ch_reg;
            s3_peak_reg <= s2_peak_reg;
            s3_prod_reg <= prod;
        end
        if (out_adv && s3_valid_reg)
        begin
            out_ch_reg     <= 3'(s3_ch_reg);
            out_peak_reg   <= s3_peak_reg;
            out_x_from_reg <= x_from;
            out_y_from_reg <= last_row_reg[s3_ch_reg];
            out_x_to_reg   <= x_next;
            out_y_to_reg   <= y_next;
        end
    end

    assign points.valid       = out_valid_reg;
    assign points.channel     = out_ch_reg;
    assign points.peak_sample = out_peak_reg;
    assign points.x_from      = out_x_from_reg;
    assign points.y_from      = out_y_from_reg;
    assign points.x_to        = out_x_to_reg;
    assign points.y_to        = out_y_to_reg;

endmodule
